FILE: rtl/cursor_linked_list_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cursor linked list engine
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CURSOR_LINKED_LIST_ENGINE_ASSERT_SVH
`define CURSOR_LINKED_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication: when ante holds, cons holds too.
`define CLLE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cursor_linked_list_engine: assertion failed");

// Next-cycle implication: when ante holds, cons holds in the following cycle.
`define CLLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cursor_linked_list_engine: assertion failed");

`else

`define CLLE_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define CLLE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/clle_pkg.sv
// ----------------------------------------------------------------------------
// clle_pkg
// Shared constants, codes and bus types of the cursor linked list engine.
// ----------------------------------------------------------------------------
package clle_pkg;

   localparam int CELL_COUNT = 16;
   localparam int VALUE_W    = 16;
   localparam int IDX_W      = $clog2(CELL_COUNT);
   localparam int LINK_W     = IDX_W + 1;
   localparam int CMD_W      = 3;
   localparam int POS_W      = 5;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 5;
   localparam int CMP_W      = (POS_W > LINK_W) ? POS_W : LINK_W;
   localparam int REQ_W      = ((CMD_W + VALUE_W + POS_W + 7) / 8) * 8;
   localparam int RSP_W      = ((STATUS_W + VALUE_W + COUNT_W + 7) / 8) * 8;

   localparam logic [LINK_W-1:0] LINK_NIL = {LINK_W{1'b1}};

   typedef enum logic [CMD_W-1:0] {
      CMD_INS_HEAD   = 3'd0,
      CMD_INS_TAIL   = 3'd1,
      CMD_INS_AT     = 3'd2,
      CMD_INS_SORTED = 3'd3,
      CMD_DEL_FIRST  = 3'd4,
      CMD_DEL_ALL    = 3'd5,
      CMD_READ       = 3'd6
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 3'd0,
      STS_FULL      = 3'd1,
      STS_EMPTY     = 3'd2,
      STS_NOT_FOUND = 3'd3,
      STS_RANGE     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_ALLOC,
      S_LINK,
      S_RELEASE,
      S_FIN
   } fsm_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } rd_req_type;

   typedef struct packed {
      logic                      val_en;
      logic                      link_en;
      logic [IDX_W-1:0]          addr;
      logic signed [VALUE_W-1:0] value;
      logic [LINK_W-1:0]         link;
   } wr_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [LINK_W-1:0]         link;
   } rd_rsp_type;

   // a link names no cell when it points at or past the end of the store
   function automatic logic is_nil(input logic [LINK_W-1:0] link);
      return link >= LINK_W'(CELL_COUNT);
   endfunction

   function automatic logic [IDX_W-1:0] to_idx(input logic [LINK_W-1:0] link);
      return link[IDX_W-1:0];
   endfunction

endpackage

FILE: rtl/clle_cell_store.sv
// ----------------------------------------------------------------------------
// clle_cell_store
// Value and link memories with one registered read port and one write port.
// ----------------------------------------------------------------------------
module clle_cell_store (
   input  logic                 clock,
   input  logic                 reset,
   input  clle_pkg::rd_req_type rd_req,
   input  clle_pkg::wr_req_type wr_req,
   output clle_pkg::rd_rsp_type rd_rsp
);
   import clle_pkg::*;

   logic signed [VALUE_W-1:0] value_mem [CELL_COUNT];
   logic [LINK_W-1:0]         link_mem  [CELL_COUNT];

   logic [CELL_COUNT-1:0]     link_valid_ff;
   logic [CELL_COUNT-1:0]     link_valid_in;
   logic                      rd_lvalid_ff;
   logic [IDX_W-1:0]          rd_addr_ff;
   logic signed [VALUE_W-1:0] rd_value_ff;
   logic [LINK_W-1:0]         rd_link_ff;

   // link of a cell that was never written: next cell, last one null
   function automatic logic [LINK_W-1:0] init_link(input logic [IDX_W-1:0] idx);
      logic [LINK_W-1:0] wide;
      wide = {1'b0, idx};
      if (wide == LINK_W'(CELL_COUNT - 1)) begin
         return LINK_NIL;
      end
      return wide + 1'b1;
   endfunction

   always_comb begin
      link_valid_in = link_valid_ff;
      if (wr_req.link_en) begin
         link_valid_in[wr_req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_req.val_en) begin
         value_mem[wr_req.addr] <= wr_req.value;
      end
      if (wr_req.link_en) begin
         link_mem[wr_req.addr] <= wr_req.link;
      end
      if (rd_req.en) begin
         rd_value_ff <= value_mem[rd_req.addr];
         rd_link_ff  <= link_mem[rd_req.addr];
         rd_addr_ff  <= rd_req.addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_valid_ff <= '0;
         rd_lvalid_ff  <= 1'b0;
      end else begin
         link_valid_ff <= link_valid_in;
         if (rd_req.en) begin
            rd_lvalid_ff <= link_valid_ff[rd_req.addr];
         end
      end
   end

   assign rd_rsp.value = rd_value_ff;
   assign rd_rsp.link  = rd_lvalid_ff ? rd_link_ff : init_link(rd_addr_ff);

endmodule

FILE: rtl/cursor_linked_list_engine.sv
// ----------------------------------------------------------------------------
// cursor_linked_list_engine
// Singly linked list of signed values in a fixed cell store with a free list.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload (lowest bit first)
//  --------+-----------+--------------------+-----------------------------------
//  req_    | in        | req_tvalid/tready  | cmd[2:0] value[18:3] position[23:19]
//  rsp_    | out       | rsp_tvalid/tready  | status[2:0] read_value[18:3]
//          |           |                    |   removed_count[23:19]
//
//  One item at a time. An item settled at acceptance goes straight to the
//  final state. A read or a delete walks the list from the head, and a
//  delete adds a release step per cell removed; an insert walks to its place
//  where needed, then allocates a free cell and, behind a cell, links it in.
//  The single read port of the link memory sets the pace, one cell per cycle
//  while walking. The longest item is a delete-all over a full store.
//  The result waits in an output register; a new item is taken while it
//  waits, and a finished one holds in the final state until the register
//  frees. Reset is synchronous and needs no clearing pass: per-cell valid
//  bits stand in for the initial chain of links.
//
// ----------------------------------------------------------------------------
`include "cursor_linked_list_engine_assert.svh"

module cursor_linked_list_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // cmd[2:0], value[18:3], position[23:19]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // status[2:0], read_value[18:3], removed_count[23:19]
);
   import clle_pkg::*;

   // control state
   fsm_type                   state_ff, state_in;
   logic [LINK_W-1:0]         list_head_ff, list_head_in;
   logic [LINK_W-1:0]         free_head_ff, free_head_in;
   logic [LINK_W-1:0]         length_ff, length_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // working registers of the item in flight
   cmd_type                   cmd_ff, cmd_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [LINK_W-1:0]         prev_ff, prev_in;
   logic [LINK_W-1:0]         cur_ff, cur_in;
   logic [LINK_W-1:0]         nxt_ff, nxt_in;
   logic [IDX_W-1:0]          alloc_ff, alloc_in;
   logic [LINK_W-1:0]         steps_ff, steps_in;
   logic [COUNT_W-1:0]        removed_ff, removed_in;
   status_type                status_ff, status_in;
   logic signed [VALUE_W-1:0] rdv_ff, rdv_in;

   // output register
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]        rsp_removed_ff, rsp_removed_in;

   // request fields
   cmd_type                   req_cmd;
   logic signed [VALUE_W-1:0] req_value;
   logic [POS_W-1:0]          req_position;
   logic                      req_fire;

   // decode
   logic [CMP_W-1:0]          ins_tgt;
   logic [CMP_W-1:0]          len_cmp;
   fsm_type                   idle_go;
   status_type                idle_status;
   logic [LINK_W-1:0]         idle_steps;
   fsm_type                   walk_go;
   fsm_type                   rel_go;
   logic                      slot_free;
   logic                      walk_less;
   logic                      walk_match;
   logic                      walk_end;
   logic                      steps_zero;

   // store ports
   rd_req_type                rd_req;
   wr_req_type                wr_req;
   rd_rsp_type                rd_rsp;

   // assertion helpers
   logic                      rw_clash;
   logic                      idle_st;
   logic                      head_nil;
   logic                      free_nil;

   clle_cell_store u_store (
      .clock  (clock),
      .reset  (reset),
      .rd_req (rd_req),
      .wr_req (wr_req),
      .rd_rsp (rd_rsp)
   );

   assign req_cmd      = cmd_type'(req_tdata[2:0]);
   assign req_value    = req_tdata[18:3];
   assign req_position = req_tdata[23:19];
   assign req_tready   = (state_ff == S_IDLE);
   assign req_fire     = req_tvalid & req_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {rsp_removed_ff, rsp_value_ff, rsp_status_ff};
   assign slot_free    = ~rsp_valid_ff | rsp_tready;

   assign len_cmp      = CMP_W'(length_ff);
   assign walk_less    = rd_rsp.value < value_ff;
   assign walk_match   = rd_rsp.value == value_ff;
   assign walk_end     = is_nil(rd_rsp.link);
   assign steps_zero   = (steps_ff == '0);

   // decide at acceptance whether the item settles at once, allocates a cell at once or walks the list
   always_comb begin
      ins_tgt     = '0;
      idle_go     = S_FIN;
      idle_status = STS_OK;
      idle_steps  = '0;
      case (req_cmd)
         CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
            case (req_cmd)
               CMD_INS_HEAD: ins_tgt = '0;
               CMD_INS_TAIL: ins_tgt = len_cmp;
               default:      ins_tgt = CMP_W'(req_position);
            endcase
            if (ins_tgt > len_cmp) begin
               idle_status = STS_RANGE;
            end else if (is_nil(free_head_ff)) begin
               idle_status = STS_FULL;
            end else if (ins_tgt == '0) begin
               idle_go = S_ALLOC;
            end else begin
               idle_go    = S_WALK;
               idle_steps = LINK_W'(ins_tgt - 1'b1);
            end
         end
         CMD_INS_SORTED: begin
            if (is_nil(free_head_ff)) begin
               idle_status = STS_FULL;
            end else if (is_nil(list_head_ff)) begin
               idle_go = S_ALLOC;
            end else begin
               idle_go = S_WALK;
            end
         end
         CMD_DEL_FIRST, CMD_DEL_ALL: begin
            if (is_nil(list_head_ff)) begin
               idle_status = STS_EMPTY;
            end else begin
               idle_go = S_WALK;
            end
         end
         CMD_READ: begin
            if (is_nil(list_head_ff)) begin
               idle_status = STS_EMPTY;
            end else if (CMP_W'(req_position) >= len_cmp) begin
               idle_status = STS_RANGE;
            end else begin
               idle_go    = S_WALK;
               idle_steps = LINK_W'(req_position);
            end
         end
         default: begin
            idle_go = S_FIN;
         end
      endcase
   end

   // one cell per cycle: the read data belongs to cur_ff
   always_comb begin
      walk_go = S_FIN;
      case (cmd_ff)
         CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
            walk_go = steps_zero ? S_ALLOC : S_WALK;
         end
         CMD_INS_SORTED: begin
            walk_go = (walk_less && !walk_end) ? S_WALK : S_ALLOC;
         end
         CMD_DEL_FIRST, CMD_DEL_ALL: begin
            if (walk_match) begin
               walk_go = S_RELEASE;
            end else begin
               walk_go = walk_end ? S_FIN : S_WALK;
            end
         end
         CMD_READ: begin
            walk_go = steps_zero ? S_FIN : S_WALK;
         end
         default: begin
            walk_go = S_FIN;
         end
      endcase
      if (cmd_ff == CMD_DEL_FIRST || is_nil(nxt_ff)) begin
         rel_go = S_FIN;
      end else begin
         rel_go = S_WALK;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = idle_go;
            end
         end
         S_WALK:    state_in = walk_go;
         S_ALLOC:   state_in = is_nil(prev_ff) ? S_FIN : S_LINK;
         S_LINK:    state_in = S_FIN;
         S_RELEASE: state_in = rel_go;
         S_FIN: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath, memory requests and output register
   always_comb begin
      list_head_in   = list_head_ff;
      free_head_in   = free_head_ff;
      length_in      = length_ff;
      cmd_in         = cmd_ff;
      value_in       = value_ff;
      prev_in        = prev_ff;
      cur_in         = cur_ff;
      nxt_in         = nxt_ff;
      alloc_in       = alloc_ff;
      steps_in       = steps_ff;
      removed_in     = removed_ff;
      status_in      = status_ff;
      rdv_in         = rdv_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_removed_in = rsp_removed_ff;
      rd_req         = '0;
      wr_req         = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in     = req_cmd;
               value_in   = req_value;
               prev_in    = LINK_NIL;
               cur_in     = list_head_ff;
               steps_in   = idle_steps;
               removed_in = '0;
               status_in  = idle_status;
               rdv_in     = '0;
               if (idle_go == S_ALLOC) begin
                  rd_req.en   = 1'b1;
                  rd_req.addr = to_idx(free_head_ff);
               end else if (idle_go == S_WALK) begin
                  rd_req.en   = 1'b1;
                  rd_req.addr = to_idx(list_head_ff);
               end
            end
         end

         S_WALK: begin
            case (cmd_ff)
               CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
                  if (steps_zero) begin
                     // cur is the cell before the insert point
                     prev_in     = cur_ff;
                     nxt_in      = rd_rsp.link;
                     rd_req.en   = 1'b1;
                     rd_req.addr = to_idx(free_head_ff);
                  end else begin
                     steps_in    = steps_ff - 1'b1;
                     cur_in      = rd_rsp.link;
                     rd_req.en   = 1'b1;
                     rd_req.addr = to_idx(rd_rsp.link);
                  end
               end
               CMD_INS_SORTED: begin
                  if (walk_less) begin
                     prev_in = cur_ff;
                     nxt_in  = rd_rsp.link;
                     rd_req.en = 1'b1;
                     if (walk_end) begin
                        rd_req.addr = to_idx(free_head_ff);
                     end else begin
                        cur_in      = rd_rsp.link;
                        rd_req.addr = to_idx(rd_rsp.link);
                     end
                  end else begin
                     // new value goes in front of the first cell not below it
                     nxt_in      = cur_ff;
                     rd_req.en   = 1'b1;
                     rd_req.addr = to_idx(free_head_ff);
                  end
               end
               CMD_DEL_FIRST, CMD_DEL_ALL: begin
                  if (walk_match) begin
                     // unhook cur now, hand it to the free list next cycle
                     nxt_in     = rd_rsp.link;
                     removed_in = removed_ff + 1'b1;
                     if (is_nil(prev_ff)) begin
                        list_head_in = rd_rsp.link;
                     end else begin
                        wr_req.link_en = 1'b1;
                        wr_req.addr    = to_idx(prev_ff);
                        wr_req.link    = rd_rsp.link;
                     end
                  end else begin
                     prev_in = cur_ff;
                     if (walk_end) begin
                        status_in = (removed_ff == '0) ? STS_NOT_FOUND : STS_OK;
                     end else begin
                        cur_in      = rd_rsp.link;
                        rd_req.en   = 1'b1;
                        rd_req.addr = to_idx(rd_rsp.link);
                     end
                  end
               end
               CMD_READ: begin
                  if (steps_zero) begin
                     rdv_in = rd_rsp.value;
                  end else begin
                     steps_in    = steps_ff - 1'b1;
                     cur_in      = rd_rsp.link;
                     rd_req.en   = 1'b1;
                     rd_req.addr = to_idx(rd_rsp.link);
                  end
               end
               default: begin
                  status_in = status_ff;
               end
            endcase
         end

         S_ALLOC: begin
            // read data is the link of the free-list head cell
            wr_req.val_en  = 1'b1;
            wr_req.link_en = 1'b1;
            wr_req.addr    = to_idx(free_head_ff);
            wr_req.value   = value_ff;
            wr_req.link    = is_nil(prev_ff) ? list_head_ff : nxt_ff;
            free_head_in   = rd_rsp.link;
            length_in      = length_ff + 1'b1;
            alloc_in       = to_idx(free_head_ff);
            if (is_nil(prev_ff)) begin
               list_head_in = free_head_ff;
            end
         end

         S_LINK: begin
            wr_req.link_en = 1'b1;
            wr_req.addr    = to_idx(prev_ff);
            wr_req.link    = {1'b0, alloc_ff};
         end

         S_RELEASE: begin
            // push the freed cell onto the free-list head
            wr_req.link_en = 1'b1;
            wr_req.addr    = to_idx(cur_ff);
            wr_req.link    = free_head_ff;
            free_head_in   = cur_ff;
            length_in      = length_ff - 1'b1;
            if (rel_go == S_WALK) begin
               cur_in      = nxt_ff;
               rd_req.en   = 1'b1;
               rd_req.addr = to_idx(nxt_ff);
            end
         end

         S_FIN: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_value_in   = rdv_ff;
               rsp_removed_in = removed_ff;
            end
         end

         default: begin
            rsp_valid_in = rsp_valid_ff & ~rsp_tready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         list_head_ff <= LINK_NIL;
         free_head_ff <= '0;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         list_head_ff <= list_head_in;
         free_head_ff <= free_head_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      value_ff       <= value_in;
      prev_ff        <= prev_in;
      cur_ff         <= cur_in;
      nxt_ff         <= nxt_in;
      alloc_ff       <= alloc_in;
      steps_ff       <= steps_in;
      removed_ff     <= removed_in;
      status_ff      <= status_in;
      rdv_ff         <= rdv_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------
   assign rw_clash = rd_req.en && (wr_req.val_en || wr_req.link_en) &&
                     (rd_req.addr == wr_req.addr);
   assign idle_st  = (state_ff == S_IDLE);
   assign head_nil = is_nil(list_head_ff);
   assign free_nil = is_nil(free_head_ff);

   // the sequencer never reads a cell in the cycle it writes it
   `CLLE_ASSERT_IMPLIES(a_no_rw_clash, clock, reset, rd_req.en, !rw_clash)
   // between items the head pointer agrees with the cell count
   `CLLE_ASSERT_IMPLIES(a_head_vs_length, clock, reset, idle_st, head_nil == (length_ff == '0))
   // between items an empty free list means a full store
   `CLLE_ASSERT_IMPLIES(a_free_vs_length, clock, reset, idle_st && free_nil, length_ff == LINK_W'(CELL_COUNT))
   // every release shortens the list by exactly one cell
   `CLLE_ASSERT_NEXT(a_release_count, clock, reset, state_ff == S_RELEASE, length_ff == $past(length_ff) - 1'b1)

endmodule

FILE: bench/tb_cursor_linked_list_engine.sv
// ----------------------------------------------------------------------------
// tb_cursor_linked_list_engine
// Self-checking bench: a queue-fed driver pushes list commands, a scoreboard
// model of the cell store and free list predicts each status, read value and
// removed count, and a monitor checks every result against the oldest one.
// ----------------------------------------------------------------------------
module tb_cursor_linked_list_engine;
   import clle_pkg::*;

   // command code with no operation behind it
   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

   localparam int IDLE_PCT     = 14;    // chance of a gap on either side
   localparam int STEADY_FROM  = 300;   // stretch of items with no gaps at all
   localparam int STEADY_TO    = 450;
   localparam int RANDOM_ITEMS = 800;
   localparam int DRAIN_CYCLES = 64;    // worst item is a delete-all over a full store
   localparam int STUCK_LIMIT  = 4000;

   // request item, cmd in the lowest bits
   typedef struct packed {
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
      logic [CMD_W-1:0]          cmd;
   } list_cmd_type;

   // result item, status in the lowest bits
   typedef struct packed {
      logic [COUNT_W-1:0]        removed_count;
      logic signed [VALUE_W-1:0] read_value;
      logic [STATUS_W-1:0]       status;
   } list_rsp_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;   // cmd, value, position
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;         // status, read_value, removed_count

   // scoreboard copy of the cell store; values stay unknown until written
   logic signed [VALUE_W-1:0] cell_val  [CELL_COUNT];
   logic [LINK_W-1:0]         cell_next [CELL_COUNT];
   logic [LINK_W-1:0]         head_link;
   logic [LINK_W-1:0]         free_link;

   list_cmd_type pending_q [$];
   list_rsp_type predicted_q [$];
   int           total_cmds   = 0;
   int           cmds_taken   = 0;
   int           fail_count   = 0;
   int           stuck_cycles = 0;

   wire steady = (cmds_taken >= STEADY_FROM) && (cmds_taken < STEADY_TO);

   cursor_linked_list_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 0;
   end

   // ------------------------------------------------------------------------
   // Scoreboard model of the list
   // ------------------------------------------------------------------------

   // link that follows prev; a null prev stands for the head register
   function automatic logic [LINK_W-1:0] link_after(input logic [LINK_W-1:0] prev);
      return (prev == LINK_NIL) ? head_link : cell_next[to_idx(prev)];
   endfunction

   function automatic void relink(input logic [LINK_W-1:0] prev,
                                  input logic [LINK_W-1:0] target);
      if (prev == LINK_NIL) begin
         head_link = target;
      end else begin
         cell_next[to_idx(prev)] = target;
      end
   endfunction

   // pop a cell off the free list and splice it in after prev
   function automatic logic [STATUS_W-1:0] take_free_cell(
         input logic [LINK_W-1:0] prev, input logic signed [VALUE_W-1:0] value);
      logic [LINK_W-1:0] slot;
      if (free_link == LINK_NIL) return STS_FULL;
      slot                    = free_link;
      free_link               = cell_next[to_idx(slot)];
      cell_val[to_idx(slot)]  = value;
      cell_next[to_idx(slot)] = link_after(prev);
      relink(prev, slot);
      return STS_OK;
   endfunction

   function automatic list_rsp_type apply_command(input list_cmd_type c);
      list_rsp_type      r;
      logic [LINK_W-1:0] prev;
      logic [LINK_W-1:0] cur;
      logic [LINK_W-1:0] nxt;
      int unsigned       len;
      int unsigned       target;
      bit                done;
      r    = '0;
      prev = LINK_NIL;
      len  = 0;
      done = 1'b0;
      cur  = head_link;
      while (cur != LINK_NIL) begin
         len++;
         cur = cell_next[to_idx(cur)];
      end
      case (c.cmd)
         CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
            target = (c.cmd == CMD_INS_HEAD) ? 0 :
                     (c.cmd == CMD_INS_TAIL) ? len : c.position;
            // position is checked before the free list
            if (target > len) begin
               r.status = STS_RANGE;
            end else begin
               repeat (target) prev = link_after(prev);
               r.status = take_free_cell(prev, c.value);
            end
         end
         CMD_INS_SORTED: begin
            // stop at the first element not less than the new value
            cur = head_link;
            while (cur != LINK_NIL && cell_val[to_idx(cur)] < c.value) begin
               prev = cur;
               cur  = cell_next[to_idx(cur)];
            end
            r.status = take_free_cell(prev, c.value);
         end
         CMD_DEL_FIRST, CMD_DEL_ALL: begin
            if (head_link == LINK_NIL) begin
               r.status = STS_EMPTY;
            end else begin
               cur = head_link;
               while (cur != LINK_NIL && !done) begin
                  nxt = cell_next[to_idx(cur)];
                  if (cell_val[to_idx(cur)] == c.value) begin
                     relink(prev, nxt);
                     cell_next[to_idx(cur)] = free_link;
                     free_link              = cur;
                     r.removed_count        = r.removed_count + 1'b1;
                     done                   = (c.cmd == CMD_DEL_FIRST);
                  end else begin
                     prev = cur;
                  end
                  cur = nxt;
               end
               r.status = (r.removed_count == 0) ? STS_NOT_FOUND : STS_OK;
            end
         end
         CMD_READ: begin
            if (head_link == LINK_NIL) begin
               r.status = STS_EMPTY;
            end else if (c.position >= len) begin
               r.status = STS_RANGE;
            end else begin
               cur = head_link;
               repeat (c.position) cur = cell_next[to_idx(cur)];
               r.read_value = cell_val[to_idx(cur)];
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   task automatic queue_cmd(input logic [CMD_W-1:0] cmd,
                            input int value, input int position);
      list_cmd_type c;
      c.cmd      = cmd;
      c.value    = VALUE_W'(value);
      c.position = POS_W'(position);
      pending_q.push_back(c);
   endtask

   // mostly a handful of small values, so that sorted inserts tie and
   // deletes find several matches
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 70) return VALUE_W'(int'($urandom_range(5)) - 2);
      if (sel < 80) return $urandom_range(1) ? {1'b0, {(VALUE_W-1){1'b1}}}
                                             : {1'b1, {(VALUE_W-1){1'b0}}};
      return VALUE_W'($urandom);
   endfunction

   initial begin : stimulus
      int           made;
      int           phase_len;
      int unsigned  insert_pct;
      int unsigned  sel;
      list_cmd_type c;

      // power-on state: every cell on the free list in index order
      for (int i = 0; i < CELL_COUNT; i++) begin
         cell_next[i] = (i + 1 < CELL_COUNT) ? LINK_W'(i + 1) : LINK_NIL;
      end
      head_link = LINK_NIL;
      free_link = '0;

      // empty list: read and both deletes report empty
      queue_cmd(CMD_READ, 0, 0);
      queue_cmd(CMD_DEL_FIRST, 5, 0);
      queue_cmd(CMD_DEL_ALL, 5, 0);
      queue_cmd(CMD_UNUSED, -1, 31);
      queue_cmd(CMD_INS_HEAD, 32767, 0);
      queue_cmd(CMD_INS_TAIL, -32768, 0);
      // position past the length is refused, position equal to it appends
      queue_cmd(CMD_INS_AT, 7, 3);
      queue_cmd(CMD_INS_AT, 1, 2);
      // sorted inserts, the second one tying with the first
      queue_cmd(CMD_INS_SORTED, 0, 0);
      queue_cmd(CMD_INS_SORTED, 0, 0);
      queue_cmd(CMD_INS_SORTED, 2, 0);
      // reads far past, at the last element and just past the end
      queue_cmd(CMD_READ, 0, 31);
      queue_cmd(CMD_READ, 0, 5);
      queue_cmd(CMD_READ, 0, 6);
      // no match, then a multi-cell delete and a single one
      queue_cmd(CMD_DEL_FIRST, 99, 0);
      queue_cmd(CMD_DEL_ALL, 0, 0);
      queue_cmd(CMD_DEL_FIRST, -32768, 0);
      queue_cmd(CMD_INS_AT, -1, 0);

      // random phases that grow the list to full, drain it, or churn
      made = 0;
      while (made < RANDOM_ITEMS) begin
         phase_len  = $urandom_range(60, 15);
         sel        = $urandom_range(2);
         insert_pct = (sel == 0) ? 88 : (sel == 1) ? 25 : 55;
         repeat (phase_len) begin
            if ($urandom_range(99) < 2) begin
               c.cmd = CMD_UNUSED;
            end else if ($urandom_range(99) < insert_pct) begin
               c.cmd = CMD_W'($urandom_range(CMD_INS_SORTED, CMD_INS_HEAD));
            end else begin
               c.cmd = CMD_W'($urandom_range(CMD_READ, CMD_DEL_FIRST));
            end
            c.value = pick_value();
            sel     = $urandom_range(9);
            c.position = (sel < 5) ? POS_W'($urandom_range(4)) :
                         (sel < 9) ? POS_W'($urandom_range(16)) : POS_W'($urandom);
            pending_q.push_back(c);
            made++;
         end
      end
      total_cmds = pending_q.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // hold until every item is taken and every result has come back
      while (cmds_taken < total_cmds || predicted_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && predicted_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Driver: present the next item, predict its result once it is taken
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_q.push_back(apply_command(req_tdata));
            cmds_taken <= cmds_taken + 1;
         end
         // advance only when the bus is free or the item on it was taken
         if (!req_tvalid || req_tready) begin
            if (pending_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: stall at random, check each taken result against the oldest
   // prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      list_rsp_type got;
      list_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (predicted_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result: status=%0d read_value=%0d removed=%0d",
                           got.status, got.read_value, got.removed_count);
               fail_count++;
            end else begin
               want = predicted_q.pop_front();
               if (got.status !== want.status || got.read_value !== want.read_value ||
                   got.removed_count !== want.removed_count) begin
                  if (fail_count < 10) begin
                     $display("result mismatch: expected status=%0d read_value=%0d removed=%0d",
                              want.status, want.read_value, want.removed_count);
                     $display("                 got      status=%0d read_value=%0d removed=%0d",
                              got.status, got.read_value, got.removed_count);
                  end
                  fail_count++;
               end
            end
         end
      end
   end

   // watchdog: drop the run when no item moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

endmodule
